FILE: hdl/dttc_pkg.sv
// shared constants, codes and control structs for the descriptor table cache
`default_nettype none

package dttc_pkg;

	localparam int MAX_SLOTS  = 16;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W      = 5;
	localparam int HIT_W      = 8;
	localparam int SCORE_W    = 15;
	localparam int HASH_W     = 32;
	localparam int CMD_W      = 2;
	localparam int NUM_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int GRANT_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [SCORE_W-1:0] SCORE_MAX  = {SCORE_W{1'b1}};
	localparam logic [CNT_W-1:0]   SLOTS_INIT = CNT_W'(16);
	localparam logic [HIT_W-1:0]   HIT_INIT   = HIT_W'(4);

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN   = 2'd0,
		CMD_CLOSE  = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_RENAME = 2'd3
	} cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_DESC = 2'd1,
		ST_CLOSED   = 2'd2,
		ST_NO_FREE  = 2'd3
	} status_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOTS_IN_USE = 1'd0,
		REG_HIT_SCORE    = 1'd1
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_needed;
		logic walk_last;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/dttc_ifs.sv
// valid/ready channel interfaces for command and result beats
`default_nettype none

interface dttc_in_if;
	logic                          valid;
	logic                          ready;
	logic [dttc_pkg::CMD_W-1:0]    cmd;
	logic [dttc_pkg::NUM_W-1:0]    descriptor_number;
	logic                          has_name;
	logic [dttc_pkg::HASH_W-1:0]   name_hash;
	logic [dttc_pkg::HASH_W-1:0]   new_name_hash;

	modport source (output valid, cmd, descriptor_number, has_name, name_hash,
		new_name_hash, input ready);
	modport sink (input valid, cmd, descriptor_number, has_name, name_hash,
		new_name_hash, output ready);
endinterface

interface dttc_out_if;
	logic                          valid;
	logic                          ready;
	logic [dttc_pkg::STATUS_W-1:0] status;
	logic [dttc_pkg::GRANT_W-1:0]  granted_number;
	logic                          name_hit;

	modport source (output valid, status, granted_number, name_hit, input ready);
	modport sink (input valid, status, granted_number, name_hit, output ready);
endinterface

`default_nettype wire

FILE: hdl/dttc_ctrl.sv
// sequencer: accept, walk the slot table, finish and hold the result beat
`default_nettype none

module dttc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dttc_pkg::ctrl_cmd_t    cmd,
	input  wire dttc_pkg::dp_stat_t stat
);
	import dttc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.step   = (state_q == S_WALK) && stat.walk_needed;
	assign cmd.finish = (state_q == S_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_WALK;
				end
				S_WALK: begin
					if (!stat.walk_needed || stat.walk_last)
						state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && stat.walk_last |=> state_q == S_FINISH)
		else $error("walk did not end at last slot");
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished item gave no result beat");
`endif

endmodule

`default_nettype wire

FILE: hdl/dttc_dpath.sv
// slot table, config registers, walk and selection logic, result register
`default_nettype none

module dttc_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dttc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dttc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [dttc_pkg::CMD_W-1:0]     in_cmd,
	input  wire logic [dttc_pkg::NUM_W-1:0]     in_number,
	input  wire logic                           in_has_name,
	input  wire logic [dttc_pkg::HASH_W-1:0]    in_name_hash,
	input  wire logic [dttc_pkg::HASH_W-1:0]    in_new_name_hash,
	input  wire dttc_pkg::ctrl_cmd_t            cmd,
	output dttc_pkg::dp_stat_t                  stat,
	output logic [dttc_pkg::STATUS_W-1:0]       status,
	output logic [dttc_pkg::GRANT_W-1:0]        granted_number,
	output logic                                name_hit
);
	import dttc_pkg::*;

	// slot table
	logic [MAX_SLOTS-1:0] slot_open_q;
	logic [SCORE_W-1:0]   score_q [MAX_SLOTS];
	logic [HASH_W-1:0]    hash_q  [MAX_SLOTS];

	// config
	logic [CNT_W-1:0] slots_q;
	logic [HIT_W-1:0] hit_q;

	// item being worked
	logic [CMD_W-1:0]  cmd_q;
	logic [NUM_W-1:0]  num_q;
	logic              has_name_q;
	logic [HASH_W-1:0] name_q;
	logic [HASH_W-1:0] new_name_q;

	// walk and selection
	logic [SLOT_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  pick_q;
	logic [SCORE_W-1:0] best_q;
	logic               found_q;
	logic               matched_q;

	// result beat
	logic [STATUS_W-1:0] status_q;
	logic [GRANT_W-1:0]  granted_q;
	logic                name_hit_q;

	cmd_code_t          cmd_code;
	logic [CNT_W-1:0]   count;
	logic [SCORE_W-1:0] cur_score;
	logic [SCORE_W-1:0] aged;
	logic               cur_open;
	logic               hash_eq;
	logic               num_bad;
	logic [SLOT_W-1:0]  num_idx;
	logic [SCORE_W:0]   score_sum;
	logic [SCORE_W-1:0] sat_score;

	always_comb begin
		cmd_code  = cmd_code_t'(cmd_q);
		count     = (slots_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slots_q;
		cur_score = score_q[idx_q];
		cur_open  = slot_open_q[idx_q];
		hash_eq   = (hash_q[idx_q] == name_q);
		aged      = (has_name_q && cur_score > SCORE_W'(1)) ? cur_score - SCORE_W'(1)
			: cur_score;
		num_bad   = (num_q == '0) || (num_q > NUM_W'(count));
		num_idx   = SLOT_W'(num_q - NUM_W'(1));
		score_sum = {1'b0, best_q} + (SCORE_W+1)'(hit_q);
		sat_score = (score_sum >= {1'b0, SCORE_MAX}) ? SCORE_MAX : score_sum[SCORE_W-1:0];
		stat.walk_needed = (cmd_code == CMD_OPEN || cmd_code == CMD_RENAME) &&
			(count != '0);
		stat.walk_last   = ({1'b0, idx_q} == count - CNT_W'(1));
	end

	assign status         = status_q;
	assign granted_number = granted_q;
	assign name_hit       = name_hit_q;

	// table, config and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_open_q <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				score_q[i] <= '0;
				hash_q[i]  <= '0;
			end
			slots_q    <= SLOTS_INIT;
			hit_q      <= HIT_INIT;
			status_q   <= ST_OK;
			granted_q  <= '0;
			name_hit_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SLOTS_IN_USE: slots_q <= cfg_data[CNT_W-1:0];
					REG_HIT_SCORE:    hit_q   <= cfg_data[HIT_W-1:0];
				endcase
			end
			if (cmd.step) begin
				case (cmd_code)
					CMD_OPEN: begin
						if (!cur_open && has_name_q)
							score_q[idx_q] <= aged;
					end
					CMD_RENAME: begin
						if (cur_score != '0 && hash_eq)
							hash_q[idx_q] <= new_name_q;
					end
					default: ;
				endcase
			end
			if (cmd.finish) begin
				case (cmd_code)
					CMD_OPEN: begin
						if (!found_q) begin
							status_q   <= ST_NO_FREE;
							granted_q  <= '0;
							name_hit_q <= 1'b0;
						end else begin
							status_q            <= ST_OK;
							slot_open_q[pick_q] <= 1'b1;
							granted_q  <= GRANT_W'(pick_q) + GRANT_W'(1);
							name_hit_q <= has_name_q && matched_q && best_q != '0;
							if (has_name_q) begin
								if (matched_q && best_q != '0) begin
									score_q[pick_q] <= sat_score;
								end else begin
									score_q[pick_q] <= SCORE_W'(hit_q);
									hash_q[pick_q]  <= name_q;
								end
							end
						end
					end
					CMD_CLOSE, CMD_CHECK: begin
						name_hit_q <= 1'b0;
						if (num_bad) begin
							status_q  <= ST_BAD_DESC;
							granted_q <= '0;
						end else if (!slot_open_q[num_idx]) begin
							status_q  <= ST_CLOSED;
							granted_q <= '0;
						end else if (cmd_code == CMD_CLOSE) begin
							status_q             <= ST_OK;
							granted_q            <= '0;
							slot_open_q[num_idx] <= 1'b0;
						end else begin
							status_q  <= ST_OK;
							granted_q <= num_q[GRANT_W-1:0];
						end
					end
					default: begin
						status_q   <= ST_OK;
						granted_q  <= '0;
						name_hit_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// item capture and selection over the walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= in_cmd;
			num_q      <= in_number;
			has_name_q <= in_has_name;
			name_q     <= in_name_hash;
			new_name_q <= in_new_name_hash;
			idx_q      <= '0;
			pick_q     <= '0;
			best_q     <= '0;
			found_q    <= 1'b0;
			matched_q  <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + SLOT_W'(1);
			// first closed hash match wins, else first least aged score
			if (cmd_code == CMD_OPEN && !cur_open && !matched_q) begin
				if (has_name_q && hash_eq) begin
					pick_q    <= idx_q;
					best_q    <= aged;
					found_q   <= 1'b1;
					matched_q <= 1'b1;
				end else if (!found_q || aged < best_q) begin
					pick_q  <= idx_q;
					best_q  <= aged;
					found_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> ({1'b0, idx_q} < count))
		else $error("walk index beyond active slots");
	a_open_grants: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && cmd_code == CMD_OPEN && found_q |=>
			granted_q != '0 && status_q == ST_OK)
		else $error("open found a slot but granted none");
	a_hit_is_open: assert property (@(posedge clk) disable iff (!arst_n)
		name_hit_q |-> status_q == ST_OK && granted_q != '0)
		else $error("name hit without a granted slot");
`endif

endmodule

`default_nettype wire

FILE: hdl/descriptor_table_temporal_cache.sv
// top level: descriptor slot allocator with an aging name-hash cache
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        cmd, descriptor_number, has_name, name_hash,
//                                   new_name_hash
//  rsp      out  valid/ready        status, granted_number, name_hit
//  cfg      in   cfg_we (no wait)   cfg_index, cfg_data
//
// open and rename walk the active slots (slots_in_use, capped at 16) one per cycle;
// close, check and an empty table skip the walk. the result is registered after
// the walk, and the sequencer then goes back to idle to take the next item.
// one item is worked at a time; req is ready only when the sequencer is idle.
// the result register lets the next item be taken while a result waits;
// a finished item stalls only while the previous result is still held.
// reset clears the slot table and loads the config registers with their defaults at once.
`default_nettype none

module descriptor_table_temporal_cache (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dttc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dttc_pkg::CFG_DATA_W-1:0] cfg_data,
	dttc_in_if.sink                             req,
	dttc_out_if.source                          rsp
);
	import dttc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	dttc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	dttc_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_cmd           (req.cmd),
		.in_number        (req.descriptor_number),
		.in_has_name      (req.has_name),
		.in_name_hash     (req.name_hash),
		.in_new_name_hash (req.new_name_hash),
		.cmd              (cmd),
		.stat             (stat),
		.status           (rsp.status),
		.granted_number   (rsp.granted_number),
		.name_hit         (rsp.name_hit)
	);

endmodule

`default_nettype wire
